// ===== rtl/bitmap_free_slot_allocator_macros.svh =====
// Assertion macros shared by the bitmap free-slot allocator RTL.
`ifndef BITMAP_FREE_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_FREE_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BFSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfsa assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BFSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfsa assertion failed");

`endif

// ===== rtl/bfsa_pkg.sv =====
// Types and constants of the bitmap free-slot allocator.
`timescale 1ns / 1ps
package bfsa_pkg;

  localparam int MAX_SLOTS  = 4096;
  localparam int WORD_BITS  = 16;
  localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = $clog2(WORD_COUNT);
  localparam int IDX_W      = 12;
  localparam int SIZE_W     = 13;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADCMD = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [SIZE_W-1:0] found;
  } res_t;

endpackage

// ===== rtl/bitmap_free_slot_allocator.sv =====
// Top level: size register, output register, sequencer and bitmap RAM.
// Path to out_tvalid: S_IDLE, then S_RMW for set/clear or S_SCAN for a find (none if rejected),
//   then S_RESP and the output register. A new item is taken only in S_IDLE, after the result
//   leaves S_RESP. The scan reads one 16-bit bitmap word per cycle; out_tready stalls hold S_RESP.
// Reset: synchronous active-low rst_n; every slot reads free (per-word valid flops cleared),
//   bits_in_use returns to 4096. No clearing pass.
`timescale 1ns / 1ps
module bitmap_free_slot_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] slot_index
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [12:0] found_index
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata   // bits_in_use
);

  localparam int SW = bfsa_pkg::SIZE_W;

  logic [SW-1:0]  bits_in_use_r;
  logic [SW-1:0]  size_eff;
  logic           out_valid_r;
  bfsa_pkg::res_t out_res_r;
  logic           res_valid;
  logic           res_ready;
  bfsa_pkg::res_t res;

  logic                           ram_we;
  logic [bfsa_pkg::WADDR_W-1:0]   ram_waddr;
  logic [bfsa_pkg::WADDR_W-1:0]   ram_raddr;
  logic [bfsa_pkg::WORD_BITS-1:0] ram_wdata;
  logic [bfsa_pkg::WORD_BITS-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= SW'(bfsa_pkg::MAX_SLOTS);
    end else if (cfg_we) begin
      bits_in_use_r <= cfg_wdata;
    end
  end

  assign size_eff = (bits_in_use_r > SW'(bfsa_pkg::MAX_SLOTS)) ?
                    SW'(bfsa_pkg::MAX_SLOTS) : bits_in_use_r;

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.found};
  assign out_tuser  = out_res_r.status;

  bfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_idx    (in_tdata[bfsa_pkg::IDX_W-1:0]),
    .size      (size_eff),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  bfsa_ram #(
    .WIDTH (bfsa_pkg::WORD_BITS),
    .DEPTH (bfsa_pkg::WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/bfsa_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module bfsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bfsa_ctrl.sv =====
// Command sequencer: read-modify-write of bitmap words and first-free scan.
`timescale 1ns / 1ps
`include "bitmap_free_slot_allocator_macros.svh"
module bfsa_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [1:0]                     in_cmd,
  input  logic [bfsa_pkg::IDX_W-1:0]     in_idx,
  input  logic [bfsa_pkg::SIZE_W-1:0]    size,
  output logic [bfsa_pkg::WADDR_W-1:0]   ram_raddr,
  output logic                           ram_we,
  output logic [bfsa_pkg::WADDR_W-1:0]   ram_waddr,
  output logic [bfsa_pkg::WORD_BITS-1:0] ram_wdata,
  input  logic [bfsa_pkg::WORD_BITS-1:0] ram_rdata,
  output logic                           res_valid,
  input  logic                           res_ready,
  output bfsa_pkg::res_t                 res
);

  localparam int WB = bfsa_pkg::WORD_BITS;
  localparam int BW = bfsa_pkg::BIT_W;
  localparam int AW = bfsa_pkg::WADDR_W;
  localparam int SW = bfsa_pkg::SIZE_W;

  bfsa_pkg::state_t state_r, state_nxt;
  bfsa_pkg::cmd_t   cmd_r, cmd_nxt;
  bfsa_pkg::res_t   res_r, res_nxt;
  logic [AW-1:0]    w_r, w_nxt;
  logic [BW-1:0]    bit_r, bit_nxt;
  logic [SW-1:0]    size_r, size_nxt;
  logic [bfsa_pkg::WORD_COUNT-1:0] vld_r, vld_nxt;

  bfsa_pkg::cmd_t   cmd_in;
  logic [SW-1:0]    size_m1;
  logic [AW-1:0]    last_w;
  logic [BW-1:0]    lim;
  logic [WB-1:0]    word_eff;
  logic [WB-1:0]    scan_word;
  logic             hit;
  logic [BW-1:0]    pos;
  logic             in_fire;

  assign cmd_in   = bfsa_pkg::cmd_t'(in_cmd);
  assign size_m1  = size_r - SW'(1);
  assign last_w   = size_m1[BW +: AW];
  assign lim      = size_r[BW-1:0];
  assign word_eff = vld_r[w_r] ? ram_rdata : '0;
  assign in_fire  = in_tvalid && in_tready;

  // Slots at or above the size count as used on the last word.
  always_comb begin
    scan_word = word_eff;
    if (w_r == last_w && lim != '0) begin
      for (int b = 0; b < WB; b++) begin
        if (BW'(b) >= lim) scan_word[b] = 1'b1;
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (!scan_word[b]) begin
        hit = 1'b1;
        pos = BW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfsa_pkg::S_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    res_r  <= res_nxt;
    w_r    <= w_nxt;
    bit_r  <= bit_nxt;
    size_r <= size_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    w_nxt     = w_r;
    bit_nxt   = bit_r;
    size_nxt  = size_r;
    vld_nxt   = vld_r;
    in_tready = 1'b0;
    res_valid = 1'b0;
    ram_raddr = w_r;
    ram_we    = 1'b0;
    ram_waddr = w_r;
    ram_wdata = word_eff;
    case (state_r)
      bfsa_pkg::S_IDLE: begin
        in_tready = 1'b1;
        ram_raddr = '0;
        if (in_tvalid) begin
          cmd_nxt  = cmd_in;
          size_nxt = size;
          res_nxt  = '{status: bfsa_pkg::ST_OK, found: '0};
          case (cmd_in)
            bfsa_pkg::CMD_CLEAR, bfsa_pkg::CMD_SET: begin
              if ({1'b0, in_idx} >= size) begin
                res_nxt.status = bfsa_pkg::ST_RANGE;
                state_nxt      = bfsa_pkg::S_RESP;
              end else begin
                w_nxt     = in_idx[BW +: AW];
                bit_nxt   = in_idx[BW-1:0];
                ram_raddr = in_idx[BW +: AW];
                state_nxt = bfsa_pkg::S_RMW;
              end
            end
            bfsa_pkg::CMD_FIND: begin
              if (size == '0) begin
                res_nxt.status = bfsa_pkg::ST_FULL;
                state_nxt      = bfsa_pkg::S_RESP;
              end else begin
                w_nxt     = '0;
                state_nxt = bfsa_pkg::S_SCAN;
              end
            end
            default: begin
              res_nxt.status = bfsa_pkg::ST_BADCMD;
              state_nxt      = bfsa_pkg::S_RESP;
            end
          endcase
        end
      end
      bfsa_pkg::S_RMW: begin
        ram_we = 1'b1;
        if (cmd_r == bfsa_pkg::CMD_SET) begin
          ram_wdata = word_eff | (WB'(1) << bit_r);
        end else begin
          ram_wdata = word_eff & ~(WB'(1) << bit_r);
        end
        vld_nxt[w_r] = 1'b1;
        state_nxt    = bfsa_pkg::S_RESP;
      end
      bfsa_pkg::S_SCAN: begin
        ram_raddr = w_r + AW'(1);
        if (hit) begin
          res_nxt.found = SW'({w_r, pos});
          state_nxt     = bfsa_pkg::S_RESP;
        end else if (w_r == last_w) begin
          res_nxt.status = bfsa_pkg::ST_FULL;
          res_nxt.found  = size_r;
          state_nxt      = bfsa_pkg::S_RESP;
        end else begin
          w_nxt = w_r + AW'(1);
        end
      end
      bfsa_pkg::S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = bfsa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bfsa_pkg::S_IDLE;
      end
    endcase
  end

  assign res = res_r;

  `BFSA_ASSERT_NXT(a_accept_leaves_idle, in_fire, state_r != bfsa_pkg::S_IDLE)
  `BFSA_ASSERT_IMP(a_write_only_in_rmw, ram_we, state_r == bfsa_pkg::S_RMW)
  `BFSA_ASSERT_IMP(a_full_only_from_find, res_valid && res_r.status == bfsa_pkg::ST_FULL, cmd_r == bfsa_pkg::CMD_FIND)
  `BFSA_ASSERT_IMP(a_scan_in_bounds, state_r == bfsa_pkg::S_SCAN, w_r <= last_w)

endmodule

// ===== tb/tb.sv =====
// Testbench for the bitmap free-slot allocator: directed and random command streams.
`timescale 1ns / 1ps
module tb;

  localparam int ITEM_TARGET = 1950;
  localparam int IDX_W       = bfsa_pkg::IDX_W;
  localparam int SIZE_W      = bfsa_pkg::SIZE_W;
  localparam int WORD_BITS   = bfsa_pkg::WORD_BITS;
  localparam int WORD_COUNT  = bfsa_pkg::WORD_COUNT;
  localparam int MAX_SLOTS   = bfsa_pkg::MAX_SLOTS;
  localparam int BIT_W       = bfsa_pkg::BIT_W;
  localparam int WADDR_W     = bfsa_pkg::WADDR_W;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;   // [11:0] slot_index
  logic [1:0]        in_tuser = '0;   // [1:0] cmd
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;       // [12:0] found_index
  logic [1:0]        out_tuser;       // [1:0] status
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // Shadow copy of the allocator
  logic [WORD_BITS-1:0] slot_map [WORD_COUNT];
  logic [SIZE_W-1:0]    slot_limit;
  bfsa_pkg::res_t       pending_results [$];

  bit quiet = 1'b0;
  int hold_cycles = 0;
  int items_sent = 0;
  int results_seen = 0;
  int full_finds = 0;
  int size_writes = 0;
  int err_count = 0;

  bitmap_free_slot_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int eff_size();
    return (slot_limit > SIZE_W'(MAX_SLOTS)) ? MAX_SLOTS : int'(slot_limit);
  endfunction

  function automatic bfsa_pkg::res_t apply_slot_cmd(bfsa_pkg::cmd_t op,
                                                    logic [IDX_W-1:0] idx);
    bfsa_pkg::res_t r;
    int eff;
    bit hit;
    eff = eff_size();
    r.status = bfsa_pkg::ST_OK;
    r.found = '0;
    hit = 1'b0;
    case (op)
      bfsa_pkg::CMD_CLEAR, bfsa_pkg::CMD_SET: begin
        if (int'(idx) >= eff) r.status = bfsa_pkg::ST_RANGE;
        else slot_map[idx[IDX_W-1:BIT_W]][idx[BIT_W-1:0]] = (op == bfsa_pkg::CMD_SET);
      end
      bfsa_pkg::CMD_FIND: begin
        for (int i = 0; i < eff && !hit; i++) begin
          if (!slot_map[WADDR_W'(i / WORD_BITS)][BIT_W'(i % WORD_BITS)]) begin
            hit = 1'b1;
            r.found = SIZE_W'(i);
          end
        end
        if (!hit) begin
          r.status = bfsa_pkg::ST_FULL;
          r.found = SIZE_W'(eff);
        end
      end
      default: r.status = bfsa_pkg::ST_BADCMD;
    endcase
    return r;
  endfunction

  task automatic send_item(input bfsa_pkg::cmd_t op, input logic [IDX_W-1:0] idx,
                           output bfsa_pkg::res_t want);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {{(16-IDX_W){1'b0}}, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = apply_slot_cmd(op, idx);
    pending_results.push_back(want);
    items_sent++;
    if (!quiet && $urandom_range(0, 99) < 18) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_limit = v;
    size_writes++;
  endtask

  // find, then claim the slot it reports
  task automatic allocate(output bit got);
    bfsa_pkg::res_t r;
    send_item(bfsa_pkg::CMD_FIND, IDX_W'($urandom_range(0, 4095)), r);
    got = (r.status == bfsa_pkg::ST_OK);
    if (got) send_item(bfsa_pkg::CMD_SET, r.found[IDX_W-1:0], r);
  endtask

  task automatic random_op();
    bfsa_pkg::res_t r;
    int eff;
    int pick;
    int idx;
    bit got;
    eff = eff_size();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      allocate(got);
    end else if (pick < 70) begin
      idx = (eff > 0) ? $urandom_range(0, eff - 1) : $urandom_range(0, 4095);
      for (int t = 0; t < 8 && eff > 0; t++) begin
        if (slot_map[WADDR_W'(idx / WORD_BITS)][BIT_W'(idx % WORD_BITS)]) break;
        idx = $urandom_range(0, eff - 1);
      end
      send_item(bfsa_pkg::CMD_CLEAR, IDX_W'(idx), r);
    end else if (pick < 80) begin
      send_item(bfsa_pkg::CMD_FIND, IDX_W'($urandom_range(0, 4095)), r);
    end else if (pick < 90) begin
      send_item($urandom_range(0, 1) ? bfsa_pkg::CMD_SET : bfsa_pkg::CMD_CLEAR,
                IDX_W'($urandom_range(0, 4095)), r);
    end else if (pick < 95) begin
      send_item(bfsa_pkg::CMD_BAD, IDX_W'($urandom_range(0, 4095)), r);
    end else begin
      // right at or just past the size boundary
      if (eff == 0) idx = 0;
      else if (eff >= 4096 || $urandom_range(0, 1)) idx = eff - 1;
      else idx = eff;
      send_item($urandom_range(0, 1) ? bfsa_pkg::CMD_SET : bfsa_pkg::CMD_CLEAR,
                IDX_W'(idx), r);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    bfsa_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d found_index %0d",
               out_tuser, out_tdata[SIZE_W-1:0]);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.status == bfsa_pkg::ST_FULL) full_finds++;
        if (out_tuser !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_tuser);
          err_count++;
        end
        if (out_tdata[SIZE_W-1:0] !== want.found) begin
          $error("found_index mismatch: expected %0d, got %0d", want.found,
                 out_tdata[SIZE_W-1:0]);
          err_count++;
        end
      end
    end
  end

  // Result side flow control
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 99) >= 18);
    end
  end

  task automatic test_reset_state();
    bfsa_pkg::res_t r;
    send_item(bfsa_pkg::CMD_FIND, 12'hFFF, r);
    send_item(bfsa_pkg::CMD_SET, 12'd0, r);
    send_item(bfsa_pkg::CMD_SET, 12'hFFF, r);
    send_item(bfsa_pkg::CMD_FIND, 12'd0, r);
    send_item(bfsa_pkg::CMD_CLEAR, 12'd0, r);
    send_item(bfsa_pkg::CMD_FIND, 12'h555, r);
    send_item(bfsa_pkg::CMD_BAD, 12'hFFF, r);
    send_item(bfsa_pkg::CMD_BAD, 12'd0, r);
    send_item(bfsa_pkg::CMD_CLEAR, 12'hFFF, r);
  endtask

  task automatic test_size_extremes();
    bfsa_pkg::res_t r;
    set_size(13'd0);
    send_item(bfsa_pkg::CMD_FIND, 12'd0, r);
    send_item(bfsa_pkg::CMD_SET, 12'd0, r);
    send_item(bfsa_pkg::CMD_CLEAR, 12'hFFF, r);
    set_size(13'h1FFF);
    send_item(bfsa_pkg::CMD_SET, 12'hFFF, r);
    send_item(bfsa_pkg::CMD_FIND, 12'd7, r);
    send_item(bfsa_pkg::CMD_CLEAR, 12'hFFF, r);
    set_size(13'd1);
    send_item(bfsa_pkg::CMD_SET, 12'd0, r);
    send_item(bfsa_pkg::CMD_FIND, 12'd0, r);
    send_item(bfsa_pkg::CMD_SET, 12'd1, r);
    send_item(bfsa_pkg::CMD_CLEAR, 12'd0, r);
    // partial last word: free bits above the size stay hidden
    set_size(13'd3);
    send_item(bfsa_pkg::CMD_SET, 12'd0, r);
    send_item(bfsa_pkg::CMD_SET, 12'd1, r);
    send_item(bfsa_pkg::CMD_SET, 12'd2, r);
    send_item(bfsa_pkg::CMD_FIND, 12'd0, r);
  endtask

  task automatic test_deep_scan();
    bit got;
    set_size(13'd4096);
    repeat (160) allocate(got);
    repeat (40) random_op();
  endtask

  task automatic test_output_stall();
    set_size(13'd48);
    wait_idle();
    hold_cycles = 400;
    repeat (24) random_op();
    wait_idle();
  endtask

  task automatic test_no_idle_stretch();
    set_size(13'($urandom_range(16, 200)));
    quiet = 1'b1;
    repeat (150) random_op();
    wait_idle();
    quiet = 1'b0;
  endtask

  task automatic test_random_sessions();
    int pick;
    int ops;
    bit got;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) set_size(13'($urandom_range(1, 64)));
      else if (pick < 80) set_size(13'($urandom_range(65, 700)));
      else if (pick < 88) set_size(13'd4096);
      else if (pick < 93) set_size(13'($urandom_range(4097, 8191)));
      else if (pick < 96) set_size(13'd0);
      else set_size(13'h1FFF);
      if (eff_size() > 0 && eff_size() <= 64 && $urandom_range(0, 99) < 30) begin
        got = 1'b1;
        while (got) allocate(got);
      end
      ops = $urandom_range(30, 90);
      repeat (ops) random_op();
    end
  endtask

  initial begin
    for (int w = 0; w < WORD_COUNT; w++) slot_map[WADDR_W'(w)] = '0;
    slot_limit = 13'd4096;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_size_extremes();
    test_deep_scan();
    test_output_stall();
    test_no_idle_stretch();
    test_random_sessions();

    wait_idle();
    repeat (260) @(posedge clk);
    $display("Sent %0d commands over %0d size settings; checked %0d results,",
             items_sent, size_writes, results_seen);
    $display("%0d of them finds on a full map.", full_finds);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
